// ===== rtl/core/mm_pkg.sv =====
`timescale 1ns / 1ps

package mm_pkg;

  // Matrix geometry: square stores of MaxDim by MaxDim words.
  localparam int MaxDim = 8;
  localparam int DimW   = $clog2(MaxDim);
  localparam int AddrW  = 2 * DimW;
  localparam int Depth  = MaxDim * MaxDim;

  // Element and accumulator widths.
  localparam int DataW = 32;
  localparam int ProdW = 2 * DataW;
  localparam int AccW  = ProdW + DimW;
  localparam int FracW = 16;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  typedef enum logic [1:0] {
    ActLoadA = 2'd0,
    ActLoadB = 2'd1,
    ActStart = 2'd2,
    ActNone  = 2'd3
  } mm_action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowsA = 2'd0,
    CfgColsA = 2'd1,
    CfgRowsB = 2'd2,
    CfgColsB = 2'd3
  } mm_cfg_e;

  // Bookkeeping that travels with each multiply-accumulate step.
  typedef struct packed {
    logic            first;
    logic            last_k;
    logic            last_res;
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
  } mm_tag_t;

  // One finished product element.
  typedef struct packed {
    logic             valid;
    logic [DimW-1:0]  row;
    logic [DimW-1:0]  col;
    logic [DataW-1:0] product;
    logic             last;
  } mm_res_t;

  // Clamp a dimension register to 1..MaxDim and return it minus one.
  function automatic logic [DimW-1:0] dim_last(input logic [CfgDataW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CfgDataW'(MaxDim)) begin
      r = DimW'(MaxDim - 1);
    end else begin
      r = DimW'(v - 1'b1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mm_store.sv =====
`timescale 1ns / 1ps

module mm_store (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [mm_pkg::AddrW-1:0] waddr_i,
  input  logic [mm_pkg::DataW-1:0] wdata_i,
  input  logic [mm_pkg::AddrW-1:0] raddr_i,
  output logic [mm_pkg::DataW-1:0] rdata_o
);
  import mm_pkg::*;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mm_mac.sv =====
`timescale 1ns / 1ps

module mm_mac (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  mm_pkg::mm_tag_t          tag_i,
  input  logic [mm_pkg::DataW-1:0] a_i,
  input  logic [mm_pkg::DataW-1:0] b_i,
  output logic                     busy_o,
  output mm_pkg::mm_res_t          res_o
);
  import mm_pkg::*;

  logic                    mul_v_q, acc_v_q, res_v_q;
  mm_tag_t                 mul_tag_q, acc_tag_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_d, acc_q;
  logic signed [AccW-1:0]  rnd;
  logic signed [AccW-FracW-1:0] scaled;
  logic [DataW-1:0]        sat;
  logic [DimW-1:0]         res_row_q, res_col_q;
  logic [DataW-1:0]        res_prod_q;
  logic                    res_last_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      acc_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      mul_v_q <= valid_i;
      acc_v_q <= mul_v_q;
      res_v_q <= acc_v_q && acc_tag_q.last_k;
    end
  end

  // Running sum: the first term of a dot product restarts it.
  always_comb begin
    if (mul_tag_q.first) begin
      acc_d = AccW'(prod_q);
    end else begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  // Round half up to Q16.16, then saturate to 32 bits.
  assign rnd    = acc_q + AccW'(1 << (FracW - 1));
  assign scaled = rnd[AccW-1:FracW];

  always_comb begin
    if (!scaled[AccW-FracW-1] && (scaled[AccW-FracW-2:DataW-1] != '0)) begin
      sat = {1'b0, {(DataW - 1){1'b1}}};
    end else if (scaled[AccW-FracW-1] && (scaled[AccW-FracW-2:DataW-1] != '1)) begin
      sat = {1'b1, {(DataW - 1){1'b0}}};
    end else begin
      sat = scaled[DataW-1:0];
    end
  end

  // Datapath registers: multiply, accumulate, result.
  always_ff @(posedge clk_i) begin
    prod_q    <= $signed(a_i) * $signed(b_i);
    mul_tag_q <= tag_i;
    if (mul_v_q) begin
      acc_q     <= acc_d;
      acc_tag_q <= mul_tag_q;
    end
    if (acc_v_q && acc_tag_q.last_k) begin
      res_row_q  <= acc_tag_q.row;
      res_col_q  <= acc_tag_q.col;
      res_prod_q <= sat;
      res_last_q <= acc_tag_q.last_res;
    end
  end

  assign busy_o        = mul_v_q || acc_v_q;
  assign res_o.valid   = res_v_q;
  assign res_o.row     = res_row_q;
  assign res_o.col     = res_col_q;
  assign res_o.product = res_prod_q;
  assign res_o.last    = res_last_q;

endmodule

// ===== rtl/core/matrix_multiply_top.sv =====
`timescale 1ns / 1ps
// Loads of A or B are taken back to back while the block is not busy.
// A start streams ra*cb dot products of kn terms through two one-port-read
// memories, one term per cycle.
// A dimension mismatch gives a single error word in the cycle after start.
// Reset sets all four dimensions to 8; store contents are undefined until loaded.
module matrix_multiply_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [2:0]                  row_i,
  input  logic [2:0]                  col_i,
  input  logic [31:0]                 value_i,
  input  logic                        cfg_we_i,
  input  logic [mm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mm_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                        out_valid_o,
  output logic [2:0]                  out_row_o,
  output logic [2:0]                  out_col_o,
  output logic [31:0]                 product_o,
  output logic                        last_o,
  output logic                        error_o
);
  import mm_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e               state_d, state_q;
  logic [CfgDataW-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [DimW-1:0]      ra_last_q, cb_last_q, kn_last_q;
  logic [DimW-1:0]      i_d, i_q, j_d, j_q, k_d, k_q;
  logic                 accept, go, mismatch;
  logic                 err_d, err_q;
  logic                 rd_v_q;
  mm_tag_t              issue_tag, rd_tag_q;
  logic                 we_a, we_b;
  logic [AddrW-1:0]     waddr, raddr_a, raddr_b;
  logic [DataW-1:0]     rdata_a, rdata_b;
  logic                 mac_busy;
  mm_res_t              res;

  assign accept   = start && !busy;
  assign mismatch = dim_last(cols_a_q) != dim_last(rows_b_q);
  assign go       = accept && (mm_action_e'(action_i) == ActStart);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= CfgDataW'(MaxDim);
      cols_a_q <= CfgDataW'(MaxDim);
      rows_b_q <= CfgDataW'(MaxDim);
      cols_b_q <= CfgDataW'(MaxDim);
    end else if (cfg_we_i) begin
      unique case (mm_cfg_e'(cfg_idx_i))
        CfgRowsA: rows_a_q <= cfg_data_i;
        CfgColsA: cols_a_q <= cfg_data_i;
        CfgRowsB: rows_b_q <= cfg_data_i;
        CfgColsB: cols_b_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Store write side: loads go straight into the addressed entry.
  assign we_a  = accept && (mm_action_e'(action_i) == ActLoadA);
  assign we_b  = accept && (mm_action_e'(action_i) == ActLoadB);
  assign waddr = {row_i, col_i};

  // Read side: A walks along row i, B walks down column j.
  assign raddr_a = {i_q, k_q};
  assign raddr_b = {k_q, j_q};

  mm_store u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_store u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Tag for the term issued this cycle.
  assign issue_tag.first    = (k_q == '0);
  assign issue_tag.last_k   = (k_q == kn_last_q);
  assign issue_tag.last_res = (k_q == kn_last_q) && (i_q == ra_last_q) && (j_q == cb_last_q);
  assign issue_tag.row      = i_q;
  assign issue_tag.col      = j_q;

  // Sequencer over i, j and k.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    err_d   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (go) begin
          if (mismatch) begin
            err_d = 1'b1;
          end else begin
            state_d = StRun;
            i_d     = '0;
            j_d     = '0;
            k_d     = '0;
          end
        end
      end
      StRun: begin
        if (issue_tag.last_k) begin
          k_d = '0;
          if (j_q == cb_last_q) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
          if (issue_tag.last_res) begin
            state_d = StIdle;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      err_q   <= 1'b0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      err_q   <= err_d;
      rd_v_q  <= (state_q == StRun);
    end
  end

  // Dimensions are latched at start so a run sees one consistent set.
  always_ff @(posedge clk_i) begin
    rd_tag_q <= issue_tag;
    if (go) begin
      ra_last_q <= dim_last(rows_a_q);
      cb_last_q <= dim_last(cols_b_q);
      kn_last_q <= dim_last(rows_b_q);
    end
  end

  mm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .tag_i   (rd_tag_q),
    .a_i     (rdata_a),
    .b_i     (rdata_b),
    .busy_o  (mac_busy),
    .res_o   (res)
  );

  assign busy = (state_q == StRun) || rd_v_q || mac_busy;

  // Result word: either a product element or the single error word.
  assign out_valid_o = res.valid || err_q;
  assign out_row_o   = err_q ? '0 : res.row;
  assign out_col_o   = err_q ? '0 : res.col;
  assign product_o   = err_q ? '0 : res.product;
  assign last_o      = err_q || res.last;
  assign error_o     = err_q;

  // The error word never collides with a product word.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(err_q && res.valid))
    else $error("error word overlaps a product word");

  // A start with mismatched dimensions yields one error word next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      go && mismatch |=> out_valid_o && error_o && last_o)
    else $error("missing error word after mismatched start");

  // A run in progress always shows busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == StRun) |-> busy)
    else $error("run in progress without busy");

  // The final word of a run ends the sequencer and drains the pipe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      res.valid && res.last |-> (state_q == StIdle) && !mac_busy)
    else $error("last product word while work remains");

endmodule
